// File: design/sbls_pkg.sv
// ----------------------------------------------------------------------------
// sbls_pkg: shared types and helpers for the lightmap shading block
// Operation codes, light word type and the arithmetic shift used for the
// edge and span steps.
// ----------------------------------------------------------------------------
`default_nettype none

package sbls_pkg;

  localparam int LIGHT_W = 16;
  localparam int CNT_W   = 4;

  typedef logic [LIGHT_W-1:0] light_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TEXEL = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam light_t LIGHT_LEVEL_MASK = 16'hFF00;

  // two's complement shift right, sign filled
  function automatic light_t asr16(light_t x, logic [2:0] s);
    logic signed [LIGHT_W-1:0] sx;
    sx = $signed(x);
    return light_t'(sx >>> s);
  endfunction

endpackage

`default_nettype wire

// File: design/surface_block_lightmap_shader.sv
// ----------------------------------------------------------------------------
// surface_block_lightmap_shader: bilinear lightmap shading through a shade table
//
// Input channel (in_valid / in_stall) carries one item per accepted edge:
//   load  - writes in_table_value into the shade table at in_table_address
//   start - opens a block with four corner lights (6.8 fixed point)
//   texel - shades one texel; ignored unless a block is open
// Result channel (out_valid / out_stall) carries one shaded pixel per texel
// of an open block, with end-of-row and end-of-block flags.
// Config: cfg_write_enable / cfg_write_data set the mip level (side 16 >> mip).
// Throughput is one item per cycle while in_stall is low. The shade table read
// is registered when a texel is accepted, and the output register loads from
// it when the output is empty or the receiver is not stalling.
// When the receiver stalls, the output register and the pending table read
// hold; in_stall rises only once both are full. A load followed by a texel
// reading the same entry needs no bypass: the write lands before the read.
// Reset (rst_n low, synchronous) closes any block, clears the light state and
// the pipeline, and sets mip to 0. The shade table is not cleared; it must be
// loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module surface_block_lightmap_shader #(
  parameter int MAX_BLOCK_SIDE    = 16,
  parameter int SHADE_TABLE_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_write_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [13:0] in_table_address,
  input  logic [7:0]  in_table_value,
  input  logic [13:0] in_top_left_light,
  input  logic [13:0] in_top_right_light,
  input  logic [13:0] in_bottom_left_light,
  input  logic [13:0] in_bottom_right_light,
  input  logic [7:0]  in_texel,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_shaded_pixel,
  output logic        out_end_of_row,
  output logic        out_end_of_block
);
  import sbls_pkg::*;

  localparam int AW = $clog2(SHADE_TABLE_DEPTH);

  // configuration
  logic [1:0] mip_r;

  // block state
  light_t left_light_r,  left_light_nxt;
  light_t right_light_r, right_light_nxt;
  light_t left_step_r,   left_step_nxt;
  light_t right_step_r,  right_step_nxt;
  light_t span_light_r,  span_light_nxt;
  light_t span_step_r,   span_step_nxt;
  cnt_t   col_r,         col_nxt;
  cnt_t   row_r,         row_nxt;
  logic   active_r,      active_nxt;

  // pipeline
  logic   s1_valid_r, s1_eor_r, s1_eob_r;
  logic   out_valid_r, out_eor_r, out_eob_r;
  logic [7:0] out_pixel_r;
  logic [7:0] rd_data_r;

  logic [7:0] shade_mem [SHADE_TABLE_DEPTH];

  op_t        op;
  logic       accept, advance, shade_go;
  logic [4:0] side;
  logic [2:0] shift;
  cnt_t       col_init;
  logic       row_end, block_end;
  light_t     lookup_idx, load_idx;
  light_t     row_left, row_right;

  assign op       = op_t'(in_operation);
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign shade_go = accept && (op == OP_TEXEL) && active_r;

  // side = MAX_BLOCK_SIDE >> mip, never below one
  always_comb begin
    side = 5'(MAX_BLOCK_SIDE) >> mip_r;
    if (side == 5'd0) begin
      side = 5'd1;
    end
  end
  assign shift    = 3'd4 - {1'b0, mip_r};
  assign col_init = cnt_t'(side - 5'd1);

  assign row_end   = (col_r == '0);
  assign block_end = row_end && (({1'b0, row_r} + 5'd1) >= side);

  assign lookup_idx = (span_light_r & LIGHT_LEVEL_MASK) + {8'd0, in_texel};
  assign load_idx   = {2'b00, in_table_address};

  // edges after this texel, used when a new row begins
  assign row_left  = left_light_r + left_step_r;
  assign row_right = right_light_r + right_step_r;

  always_comb begin
    left_light_nxt  = left_light_r;
    right_light_nxt = right_light_r;
    left_step_nxt   = left_step_r;
    right_step_nxt  = right_step_r;
    span_light_nxt  = span_light_r;
    span_step_nxt   = span_step_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    active_nxt      = active_r;
    if (accept && op == OP_START) begin
      left_light_nxt  = {2'b00, in_top_left_light};
      right_light_nxt = {2'b00, in_top_right_light};
      left_step_nxt   = asr16({2'b00, in_bottom_left_light} - {2'b00, in_top_left_light},
                              shift);
      right_step_nxt  = asr16({2'b00, in_bottom_right_light} - {2'b00, in_top_right_light},
                              shift);
      row_nxt         = '0;
      active_nxt      = 1'b1;
      span_light_nxt  = {2'b00, in_top_right_light};
      span_step_nxt   = asr16({2'b00, in_top_left_light} - {2'b00, in_top_right_light},
                              shift);
      col_nxt         = col_init;
    end else if (shade_go) begin
      span_light_nxt = span_light_r + span_step_r;
      if (row_end) begin
        left_light_nxt  = row_left;
        right_light_nxt = row_right;
        if (block_end) begin
          active_nxt = 1'b0;
          row_nxt    = '0;
        end else begin
          row_nxt        = row_r + cnt_t'(1);
          span_light_nxt = row_right;
          span_step_nxt  = asr16(row_left - row_right, shift);
          col_nxt        = col_init;
        end
      end else begin
        col_nxt = col_r - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mip_r         <= '0;
      left_light_r  <= '0;
      right_light_r <= '0;
      left_step_r   <= '0;
      right_step_r  <= '0;
      span_light_r  <= '0;
      span_step_r   <= '0;
      col_r         <= '0;
      row_r         <= '0;
      active_r      <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        mip_r <= cfg_write_data;
      end
      left_light_r  <= left_light_nxt;
      right_light_r <= right_light_nxt;
      left_step_r   <= left_step_nxt;
      right_step_r  <= right_step_nxt;
      span_light_r  <= span_light_nxt;
      span_step_r   <= span_step_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      active_r      <= active_nxt;
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      // read stage refills whenever it is empty or draining
      if (advance || !s1_valid_r) begin
        s1_valid_r <= shade_go;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (shade_go) begin
      s1_eor_r <= row_end;
      s1_eob_r <= block_end;
    end
    if (advance && s1_valid_r) begin
      out_pixel_r <= rd_data_r;
      out_eor_r   <= s1_eor_r;
      out_eob_r   <= s1_eob_r;
    end
  end

  // shade table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD) begin
      shade_mem[load_idx[AW-1:0]] <= in_table_value;
    end
    if (shade_go) begin
      rd_data_r <= shade_mem[lookup_idx[AW-1:0]];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_shaded_pixel = out_pixel_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_block = out_eob_r;

  // a block end is always a row end too
  a_eob_implies_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_end_of_block || out_end_of_row))
    else $error("end of block without end of row");

  // input only stalls when both the read stage and the output are full
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // a shaded texel always enters the read stage
  a_texel_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    shade_go |=> s1_valid_r)
    else $error("accepted texel lost before the read stage");

  // the block closes only on the texel flagged as its end
  a_close_on_eob: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && shade_go && !block_end) |=> active_r)
    else $error("block closed early");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for surface_block_lightmap_shader
// Drives load, start, texel and op-three items with random gaps on both
// channels. Keeps an in-line shading predictor (corner lights, edge and span
// stepping, shade table contents) and checks every shaded pixel and its
// row/block flags in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import sbls_pkg::*;

  localparam int TABLE_DEPTH  = 16384;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct {
    op_t         op;
    logic [13:0] table_address;
    logic [7:0]  table_value;
    logic [13:0] top_left;
    logic [13:0] top_right;
    logic [13:0] bottom_left;
    logic [13:0] bottom_right;
    logic [7:0]  texel;
  } shader_item_t;

  typedef struct {
    logic [7:0] shaded_pixel;
    logic       end_of_row;
    logic       end_of_block;
  } shaded_pixel_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_write_enable;
  logic [1:0]  cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [13:0] in_table_address;
  logic [7:0]  in_table_value;
  logic [13:0] in_top_left_light;
  logic [13:0] in_top_right_light;
  logic [13:0] in_bottom_left_light;
  logic [13:0] in_bottom_right_light;
  logic [7:0]  in_texel;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_shaded_pixel;
  logic        out_end_of_row;
  logic        out_end_of_block;

  surface_block_lightmap_shader i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_write_enable      (cfg_write_enable),
    .cfg_write_data        (cfg_write_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_table_address      (in_table_address),
    .in_table_value        (in_table_value),
    .in_top_left_light     (in_top_left_light),
    .in_top_right_light    (in_top_right_light),
    .in_bottom_left_light  (in_bottom_left_light),
    .in_bottom_right_light (in_bottom_right_light),
    .in_texel              (in_texel),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_shaded_pixel      (out_shaded_pixel),
    .out_end_of_row        (out_end_of_row),
    .out_end_of_block      (out_end_of_block)
  );

  // shading predictor state
  logic [7:0]    shade_mem [TABLE_DEPTH];
  bit            shade_loaded [TABLE_DEPTH];
  light_t        left_edge, right_edge, left_step, right_step;
  light_t        span_light, span_step;
  cnt_t          column_left, row_now;
  bit            block_open;
  logic [1:0]    mip_now;
  shaded_pixel_t predicted_pixels[$];

  int mismatch_count;
  int random_items;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("surface_block_lightmap_shader regression: fail");
    $finish;
  end

  function automatic light_t sign_shift(light_t x, logic [1:0] mip);
    logic [31:0] wide;
    wide = {{16{x[15]}}, x} >> (3'd4 - {1'b0, mip});
    return wide[15:0];
  endfunction

  function automatic int block_side();
    return 16 >> mip_now;
  endfunction

  function automatic void open_row();
    span_light  = right_edge;
    span_step   = sign_shift(left_edge - right_edge, mip_now);
    column_left = cnt_t'(block_side() - 1);
  endfunction

  // entry the next texel reads; texel < 256 so the add is a concat
  function automatic logic [13:0] lookup_index(logic [7:0] texel);
    return {span_light[13:8], texel};
  endfunction

  function automatic logic [13:0] random_light();
    case ($urandom_range(0, 7))
      0: return 14'h0000;
      1: return 14'h3FFF;
      default: return 14'($urandom);
    endcase
  endfunction

  function automatic shader_item_t random_item(op_t op);
    shader_item_t it;
    it.op            = op;
    it.table_address = 14'($urandom);
    it.table_value   = 8'($urandom);
    it.top_left      = 14'($urandom);
    it.top_right     = 14'($urandom);
    it.bottom_left   = 14'($urandom);
    it.bottom_right  = 14'($urandom);
    it.texel         = 8'($urandom);
    return it;
  endfunction

  function automatic void report_mismatch(string what);
    if (mismatch_count < 10) $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endfunction

  // Drive one item, wait for it to be taken, then advance the predictor.
  task automatic issue_item(shader_item_t it);
    int            gap;
    shaded_pixel_t res;
    logic [13:0]   idx;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_operation          <= it.op;
    in_table_address      <= it.table_address;
    in_table_value        <= it.table_value;
    in_top_left_light     <= it.top_left;
    in_top_right_light    <= it.top_right;
    in_bottom_left_light  <= it.bottom_left;
    in_bottom_right_light <= it.bottom_right;
    in_texel              <= it.texel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    random_items++;
    case (it.op)
      OP_LOAD: begin
        shade_mem[it.table_address]    = it.table_value;
        shade_loaded[it.table_address] = 1'b1;
      end
      OP_START: begin
        left_edge  = light_t'(it.top_left);
        right_edge = light_t'(it.top_right);
        left_step  = sign_shift(light_t'(it.bottom_left) - light_t'(it.top_left), mip_now);
        right_step = sign_shift(light_t'(it.bottom_right) - light_t'(it.top_right), mip_now);
        row_now    = '0;
        block_open = 1'b1;
        open_row();
      end
      OP_TEXEL: if (block_open) begin
        idx              = lookup_index(it.texel);
        res.shaded_pixel = shade_mem[idx];
        res.end_of_row   = 1'b0;
        res.end_of_block = 1'b0;
        span_light       = span_light + span_step;
        if (column_left == 0) begin
          res.end_of_row = 1'b1;
          left_edge      = left_edge + left_step;
          right_edge     = right_edge + right_step;
          // mip may have changed mid-block, so compare against the live side
          if (int'(row_now) + 1 >= block_side()) begin
            res.end_of_block = 1'b1;
            block_open       = 1'b0;
            row_now          = '0;
          end else begin
            row_now = row_now + 1'b1;
            open_row();
          end
        end else begin
          column_left = column_left - 1'b1;
        end
        predicted_pixels.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Texel item; loads the entry first if the lookup would hit an unwritten one.
  task automatic send_texel(logic [7:0] texel);
    shader_item_t it;
    if (block_open && !shade_loaded[lookup_index(texel)]) begin
      it = random_item(OP_LOAD);
      it.table_address = lookup_index(texel);
      issue_item(it);
    end
    it = random_item(OP_TEXEL);
    it.texel = texel;
    issue_item(it);
  endtask

  task automatic send_start(input logic [13:0] tl, tr, bl, br);
    shader_item_t it;
    it = random_item(OP_START);
    it.top_left     = tl;
    it.top_right    = tr;
    it.bottom_left  = bl;
    it.bottom_right = br;
    issue_item(it);
  endtask

  // Drop valid, wait for all predicted pixels, then cover ignored items in flight.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mip(logic [1:0] m);
    settle();
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= m;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    mip_now = m;
  endtask

  task automatic test_extremes();
    shader_item_t it;
    write_mip(2'd3);
    it = random_item(OP_LOAD);
    it.table_address = 14'h3FFF;
    it.table_value   = 8'hFF;
    issue_item(it);
    it.table_address = 14'h0000;
    it.table_value   = 8'h00;
    issue_item(it);
    send_start(14'h0000, 14'h3FFF, 14'h3FFF, 14'h0000);
    send_texel(8'h00);
    send_texel(8'hFF);
    send_texel(8'h5A);
    send_texel(8'hA5);
    send_start(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
    repeat (4) send_texel(8'hFF);
    send_start(14'h0000, 14'h0000, 14'h0000, 14'h0000);
    repeat (4) send_texel(8'h00);
  endtask

  task automatic test_ignored_items();
    // no block open: texel and op three both drop
    send_texel(8'($urandom));
    issue_item(random_item(OP_NONE));
    send_start(random_light(), random_light(), random_light(), random_light());
    send_texel(8'($urandom));
    issue_item(random_item(OP_NONE));
    // restart abandons the half-done block
    send_start(random_light(), random_light(), random_light(), random_light());
    repeat (4) send_texel(8'($urandom));
    settle();
  endtask

  task automatic test_table_overwrite();
    shader_item_t it;
    logic [7:0]   t;
    send_start(random_light(), random_light(), random_light(), random_light());
    t = 8'($urandom);
    it = random_item(OP_LOAD);
    it.table_address = lookup_index(t);
    issue_item(it);
    it.table_value = ~it.table_value;
    issue_item(it);
    send_texel(t);
    repeat (3) send_texel(8'($urandom));
  endtask

  task automatic test_mip_mid_block();
    write_mip(2'd3);
    // edge steps from shift 1 carried over 4 rows drive the light negative
    send_start(14'h0100, 14'h0100, 14'h0000, 14'h0000);
    repeat (2) send_texel(8'($urandom));
    write_mip(2'd2);
    repeat (10) send_texel(8'($urandom));
    // shrink the side while past its last row
    send_start(random_light(), random_light(), random_light(), random_light());
    repeat (8) send_texel(8'($urandom));
    write_mip(2'd3);
    repeat (4) send_texel(8'($urandom));
  endtask

  task automatic test_random_traffic();
    int         phase;
    int         phase_start;
    int         noise;
    bit         cut;
    logic [1:0] m;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: m = 2'd0;
        1: m = 2'd3;
        default: begin
          noise = $urandom_range(0, 99);
          m = noise < 12 ? 2'd0 : noise < 35 ? 2'd1 : noise < 65 ? 2'd2 : 2'd3;
        end
      endcase
      // a block left open here sees its mip change
      write_mip(m);
      no_gaps = ($urandom_range(0, 3) == 0);
      phase_start = random_items;
      cut = 1'b0;
      while (random_items - phase_start < 150 && !cut) begin
        if (!block_open) begin
          if ($urandom_range(0, 9) == 0) begin
            send_texel(8'($urandom));
          end else begin
            send_start(random_light(), random_light(), random_light(), random_light());
          end
        end else begin
          noise = $urandom_range(0, 99);
          if (noise < 3) begin
            issue_item(random_item(OP_NONE));
          end else if (noise < 6) begin
            issue_item(random_item(OP_LOAD));
          end else if (noise < 7) begin
            send_start(random_light(), random_light(), random_light(), random_light());
          end else begin
            send_texel(8'($urandom));
          end
          if (noise == 99) cut = 1'b1;
        end
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin : result_pacing
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    shaded_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %02h row end %0b block end %0b",
                                  out_shaded_pixel, out_end_of_row, out_end_of_block));
      end else begin
        want = predicted_pixels.pop_front();
        if (out_shaded_pixel !== want.shaded_pixel || out_end_of_row !== want.end_of_row ||
            out_end_of_block !== want.end_of_block)
          report_mismatch($sformatf(
            "pixel exp %02h got %02h, row end exp %0b got %0b, block end exp %0b got %0b",
            want.shaded_pixel, out_shaded_pixel, want.end_of_row, out_end_of_row,
            want.end_of_block, out_end_of_block));
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_write_enable      = 1'b0;
    cfg_write_data        = 2'd0;
    in_valid              = 1'b0;
    in_operation          = OP_NONE;
    in_table_address      = '0;
    in_table_value        = '0;
    in_top_left_light     = '0;
    in_top_right_light    = '0;
    in_bottom_left_light  = '0;
    in_bottom_right_light = '0;
    in_texel              = '0;
    left_edge             = '0;
    right_edge            = '0;
    left_step             = '0;
    right_step            = '0;
    span_light            = '0;
    span_step             = '0;
    column_left           = '0;
    row_now               = '0;
    block_open            = 1'b0;
    mip_now               = 2'd0;
    mismatch_count        = 0;
    random_items          = 0;
    no_gaps               = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_ignored_items();
    test_table_overwrite();
    test_mip_mid_block();
    test_random_traffic();
    settle();

    if (mismatch_count == 0 && predicted_pixels.size() == 0)
      $display("surface_block_lightmap_shader regression: pass");
    else
      $display("surface_block_lightmap_shader regression: fail");
    $finish;
  end

endmodule
